/* sv/assert_macros.svh */
// assertion helpers for the sorted list engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// concurrent check on a named clock and active-low reset
`define SLE_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check on the block clock and reset
`define SLE_ASSERT(lbl, prop, msg) \
    `SLE_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`else

`define SLE_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define SLE_ASSERT(lbl, prop, msg)

`endif

`endif

/* sv/sle_pkg.sv */
package sle_pkg;

    // operation codes of an input transaction
    localparam logic [2:0] FN_INSERT     = 3'd0;
    localparam logic [2:0] FN_REM_FIRST  = 3'd1;
    localparam logic [2:0] FN_REM_LAST   = 3'd2;
    localparam logic [2:0] FN_REM_VALUE  = 3'd3;
    localparam logic [2:0] FN_FIND       = 3'd4;

    // result status codes
    localparam logic [1:0] STS_DONE      = 2'd0;
    localparam logic [1:0] STS_FULL      = 2'd1;
    localparam logic [1:0] STS_EMPTY     = 2'd2;
    localparam logic [1:0] STS_NOTFOUND  = 2'd3;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } t_state;

    // update applied by every cell in the apply cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_ALL,
        CELL_REMOVE
    } t_cell_op;

    // broadcast from the sequencer to the chain
    typedef struct packed {
        logic               cmp_en;
        t_cell_op           op;
        logic               mark_ins;
        logic signed [31:0] value;
    } t_cell_ctrl;

endpackage

/* sv/sle_cell.sv */
module sle_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sle_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_valid,
    input  logic signed [31:0]  i_prev_entry,
    input  logic                i_prev_le,
    input  logic                i_prev_eq,
    input  logic signed [31:0]  i_next_entry,
    output logic signed [31:0]  o_entry,
    output logic                o_le,
    output logic                o_eq,
    output logic                o_mark
);

    logic signed [31:0] r_entry;
    logic               r_gt;
    logic               r_eq;
    logic               w_lt;

    // ordering against the broadcast value, held from the compare cycle
    assign o_le  = i_valid && !r_gt;
    assign o_eq  = i_valid && r_eq;
    assign w_lt  = o_le && !r_eq;
    assign o_entry = r_entry;

    // insertion boundary or first equal entry
    assign o_mark = i_ctrl.mark_ins ? (!o_le && i_prev_le) : (o_eq && !i_prev_eq);

    // compare flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctrl.cmp_en) begin
            r_gt <= r_entry > i_ctrl.value;
            r_eq <= r_entry == i_ctrl.value;
        end
    end

    // entry update from the neighbours
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            sle_pkg::CELL_INSERT: begin
                if (!o_le) begin
                    r_entry <= i_prev_le ? i_ctrl.value : i_prev_entry;
                end
            end
            sle_pkg::CELL_SHIFT_ALL: begin
                r_entry <= i_next_entry;
            end
            sle_pkg::CELL_REMOVE: begin
                if (!w_lt) begin
                    r_entry <= i_next_entry;
                end
            end
            default: begin
                r_entry <= r_entry;
            end
        endcase
    end

endmodule

/* sv/sorted_list_engine_unit.sv */
// channel  | signals                           | transfer
// ---------+-----------------------------------+--------------------------------
// command  | i_start, o_busy, i_func, i_value  | start high while busy low
// result   | o_valid, o_status, o_position,    | o_valid high for one cycle,
//          | o_count, o_is_empty               | cannot be held off
//
// in each transaction the accept edge registers the compare flags in
// every cell; the apply state then shifts the chain and registers the result.
// a new command is taken in the cycle the previous result is shown.
// synchronous active-low reset empties the list; entries themselves are not cleared.
// the result side never stalls.
`include "assert_macros.svh"

module sorted_list_engine_unit #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [3:0]         o_position,
    output logic [4:0]         o_count,
    output logic               o_is_empty
);

    localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    sle_pkg::t_state     r_state, n_state;
    logic [2:0]          r_func;
    logic signed [31:0]  r_value;
    logic [CNTW-1:0]     r_fill, n_fill;
    logic                r_valid;
    logic [1:0]          r_status, n_status;
    logic [3:0]          r_position, n_position;
    logic                w_accept, w_apply;
    sle_pkg::t_cell_ctrl w_ctrl;

    logic signed [31:0]  w_entry [DEPTH];
    logic [DEPTH-1:0]    w_le, w_eq, w_mark, w_valid;
    logic                w_found, w_full, w_empty;
    logic [IDXW-1:0]     w_mark_idx;
    logic [31:0]         w_mark_wide;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sle_pkg::ST_IDLE:  if (i_start) n_state = sle_pkg::ST_APPLY;
            sle_pkg::ST_APPLY: n_state = sle_pkg::ST_IDLE;
            default:           n_state = sle_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_busy  = 1'b0;
        w_apply = 1'b0;
        unique case (r_state)
            sle_pkg::ST_IDLE:  o_busy = 1'b0;
            sle_pkg::ST_APPLY: begin
                o_busy  = 1'b1;
                w_apply = 1'b1;
            end
            default:           o_busy = 1'b0;
        endcase
    end

    assign w_accept = i_start && !o_busy;
    assign w_full   = r_fill >= CNTW'(DEPTH);
    assign w_empty  = r_fill == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sle_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // command capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
    end

    // broadcast to the chain
    always_comb begin
        w_ctrl.cmp_en   = w_accept;
        w_ctrl.value    = w_accept ? i_value : r_value;
        w_ctrl.mark_ins = r_func == sle_pkg::FN_INSERT;
        w_ctrl.op       = sle_pkg::CELL_HOLD;
        if (w_apply) begin
            case (r_func)
                sle_pkg::FN_INSERT:    if (!w_full) w_ctrl.op = sle_pkg::CELL_INSERT;
                sle_pkg::FN_REM_FIRST: if (!w_empty) w_ctrl.op = sle_pkg::CELL_SHIFT_ALL;
                sle_pkg::FN_REM_VALUE: if (w_found) w_ctrl.op = sle_pkg::CELL_REMOVE;
                default:               w_ctrl.op = sle_pkg::CELL_HOLD;
            endcase
        end
    end

    // chain of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] w_prev_entry, w_next_entry;
        logic               w_prev_le, w_prev_eq;

        assign w_valid[g] = CNTW'(g) < r_fill;

        if (g == 0) begin : g_head
            assign w_prev_entry = '0;
            assign w_prev_le    = 1'b1;
            assign w_prev_eq    = 1'b0;
        end else begin : g_body
            assign w_prev_entry = w_entry[g-1];
            assign w_prev_le    = w_le[g-1];
            assign w_prev_eq    = w_eq[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next_entry = '0;
        end else begin : g_link
            assign w_next_entry = w_entry[g+1];
        end

        sle_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_valid      (w_valid[g]),
            .i_prev_entry (w_prev_entry),
            .i_prev_le    (w_prev_le),
            .i_prev_eq    (w_prev_eq),
            .i_next_entry (w_next_entry),
            .o_entry      (w_entry[g]),
            .o_le         (w_le[g]),
            .o_eq         (w_eq[g]),
            .o_mark       (w_mark[g])
        );
    end

    // one-hot marker to index
    always_comb begin
        w_mark_idx = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_mark_idx = w_mark_idx | (w_mark[k] ? IDXW'(k) : '0);
        end
    end

    assign w_found     = |w_eq;
    assign w_mark_wide = 32'(w_mark_idx);

    // result and fill update
    always_comb begin
        n_status   = sle_pkg::STS_DONE;
        n_position = '0;
        n_fill     = r_fill;
        case (r_func) inside
            sle_pkg::FN_INSERT: begin
                if (w_full) begin
                    n_status = sle_pkg::STS_FULL;
                end else begin
                    n_position = w_mark_wide[3:0];
                    n_fill     = r_fill + 1'b1;
                end
            end
            sle_pkg::FN_REM_FIRST: begin
                if (w_empty) n_status = sle_pkg::STS_EMPTY;
                else         n_fill   = r_fill - 1'b1;
            end
            sle_pkg::FN_REM_LAST: begin
                if (w_empty) begin
                    n_status = sle_pkg::STS_EMPTY;
                end else begin
                    n_fill     = r_fill - 1'b1;
                    n_position = 4'(n_fill);
                end
            end
            sle_pkg::FN_REM_VALUE, sle_pkg::FN_FIND: begin
                if (w_empty) begin
                    n_status = sle_pkg::STS_EMPTY;
                end else if (!w_found) begin
                    n_status = sle_pkg::STS_NOTFOUND;
                end else begin
                    n_position = w_mark_wide[3:0];
                    if (r_func == sle_pkg::FN_REM_VALUE) n_fill = r_fill - 1'b1;
                end
            end
            default: n_status = sle_pkg::STS_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_apply;
            if (w_apply) r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_status   <= n_status;
            r_position <= n_position;
        end
    end

    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_position = r_position;
    assign o_count    = 5'(r_fill);
    assign o_is_empty = r_fill == '0;

    // checks
    `SLE_ASSERT(a_strobe_single, o_valid |=> !o_valid, "result strobe held for two cycles")
    `SLE_ASSERT(a_accept_result, w_accept |-> ##2 o_valid, "accepted transaction gave no result")
    `SLE_ASSERT(a_fill_bound, r_fill <= CNTW'(DEPTH), "fill count beyond depth")
    `SLE_ASSERT(a_apply_busy, w_apply |-> !w_accept, "command accepted while applying")

endmodule
